[rtl/core/pot_pkg.sv]
package pot_pkg;

    // converter resolution, only the low bits of the sample index the table
    localparam int ADC_BITS = 10;
    localparam int ROM_DEPTH = 1 << ADC_BITS;

    localparam int SAMPLE_W = 10;
    localparam int TIME_W = 32;
    localparam int DIST_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROX_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND = 2'd3;

    localparam logic [CFG_W-1:0] UPDATE_PERIOD_RST = 16'd100;
    localparam logic [CFG_W-1:0] LATCH_TIME_RST = 16'd100;
    localparam logic [CFG_W-1:0] PROX_LIMIT_RST = 16'd160;
    localparam logic [CFG_W-1:0] HYST_BAND_RST = 16'd32;

    // distance conversion constants, q16
    localparam logic [63:0] K_SCALE_Q16 = 64'd274788254;
    localparam logic [63:0] K_OFFSET_Q16 = 64'd258015;
    localparam logic [63:0] K_EXP_Q16 = 64'd61276;

    typedef enum logic [2:0] {
        ST_STARTING = 3'd0,
        ST_SCANNING = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ALERT    = 3'd3,
        ST_LOST     = 3'd4
    } track_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic [TIME_W-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        current_state;
        logic              state_changed;
        logic [DIST_W-1:0] measured_distance;
        logic              obstacle_valid;
        logic [DIST_W-1:0] obstacle_distance;
    } out_item_t;

    typedef logic [DIST_W-1:0] dist_rom_t [ROM_DEPTH];
    typedef logic [63:0] root_tab_t [17];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // one table entry: 4192.936 * v^-0.935 - 3.937, in sixteenths of a cm
    function automatic logic [DIST_W-1:0] dist_entry(input int v, input root_tab_t root);
        int          top;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] y;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] n;
        logic [15:0] f;
        top = 0;
        if (v == 0) begin
            return {DIST_W{1'b1}};
        end
        for (int i = 0; i < 31; i++) begin
            if (((v >> i) & 1) != 0) begin
                top = i;
            end
        end
        m = 64'(v) << (30 - top);
        lg = 64'(top) << 16;
        // log2 fraction by repeated squaring of the mantissa
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                lg = lg | (64'd1 << (15 - i));
            end
        end
        y = (lg * K_EXP_Q16) >> 16;
        n = y >> 16;
        f = y[15:0];
        p = 64'd1 << 32;
        for (int i = 1; i <= 16; i++) begin
            if (f[16-i]) begin
                p = (p * root[i]) >> 32;
            end
        end
        q = (K_SCALE_Q16 * p) >> 32;
        q = (n < 64'd63) ? (q >> n) : 64'd0;
        if (q < K_OFFSET_Q16) begin
            return '0;
        end
        q = (q - K_OFFSET_Q16) >> 12;
        return (q > 64'd65535) ? {DIST_W{1'b1}} : q[DIST_W-1:0];
    endfunction

    function automatic dist_rom_t build_dist_rom();
        dist_rom_t rom;
        root_tab_t root;
        // r_k = 2^(-2^-k) in q32
        root[0] = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) begin
            root[i] = isqrt64(root[i-1] << 32);
        end
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = dist_entry(i, root);
        end
        return rom;
    endfunction

    localparam dist_rom_t DIST_ROM = build_dist_rom();

endpackage

[rtl/core/proximity_obstacle_tracker_unit.sv]
// channel   signals                               direction  transfer when
// in        in_valid in_ready in_data             in         in_valid & in_ready
// out       out_valid out_ready out_data          out        out_valid & out_ready
// cfg       cfg_we cfg_index cfg_data             in         cfg_we
//
// one item per cycle sustained while the output is not stalled; a result
// passes the input stage, which registers the distance table read, then
// the update-period check and tracker state machine into the result register
// rst_n clears all control state and loads the register defaults
// a stalled output holds its result; the input side keeps taking items as long
// as the output register is free or being emptied in the same cycle
module proximity_obstacle_tracker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pot_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pot_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [pot_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pot_pkg::CFG_W-1:0]            cfg_data
);

    // configuration registers
    logic [pot_pkg::CFG_W-1:0] update_period_reg;
    logic [pot_pkg::CFG_W-1:0] latch_time_reg;
    logic [pot_pkg::CFG_W-1:0] prox_limit_reg;
    logic [pot_pkg::CFG_W-1:0] hyst_band_reg;

    // input stage: time stamp and table distance
    logic                       s1_valid_reg;
    logic [pot_pkg::TIME_W-1:0] s1_now_reg;
    logic [pot_pkg::DIST_W-1:0] s1_dist_reg;

    // tracker state
    pot_pkg::track_state_t      fsm_state_reg;
    pot_pkg::track_state_t      fsm_state_next;
    pot_pkg::track_state_t      pending_state_reg;
    pot_pkg::track_state_t      pending_state_next;
    logic [pot_pkg::TIME_W-1:0] last_update_reg;
    logic [pot_pkg::TIME_W-1:0] last_update_next;
    logic [pot_pkg::TIME_W-1:0] last_change_reg;
    logic [pot_pkg::TIME_W-1:0] last_change_next;
    logic [pot_pkg::DIST_W-1:0] last_dist_reg;
    logic [pot_pkg::DIST_W-1:0] last_dist_next;
    logic [pot_pkg::DIST_W-1:0] tracked_dist_reg;
    logic [pot_pkg::DIST_W-1:0] tracked_dist_next;
    logic                       tracked_valid_reg;
    logic                       tracked_valid_next;

    // result register
    logic                       out_valid_reg;
    pot_pkg::out_item_t         out_data_reg;
    pot_pkg::out_item_t         out_data_next;

    logic in_fire;
    logic out_free;
    logic s1_fire;

    logic [pot_pkg::TIME_W-1:0] since_update;
    logic [pot_pkg::TIME_W-1:0] since_change;
    logic                       accept;
    logic                       changed;
    logic                       latched;
    logic                       blocked;
    logic [pot_pkg::DIST_W-1:0] obst_dist;
    logic                       obst_valid;
    logic [pot_pkg::DIST_W:0]   near_limit;

    // handshake: output register frees when empty or being taken
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_period_reg <= pot_pkg::UPDATE_PERIOD_RST;
            latch_time_reg    <= pot_pkg::LATCH_TIME_RST;
            prox_limit_reg    <= pot_pkg::PROX_LIMIT_RST;
            hyst_band_reg     <= pot_pkg::HYST_BAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pot_pkg::REG_UPDATE_PERIOD: update_period_reg <= cfg_data;
                pot_pkg::REG_LATCH_TIME:    latch_time_reg    <= cfg_data;
                pot_pkg::REG_PROX_LIMIT:    prox_limit_reg    <= cfg_data;
                pot_pkg::REG_HYST_BAND:     hyst_band_reg     <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input stage payload, table read registered here
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_now_reg  <= in_data.now_ms;
            s1_dist_reg <= pot_pkg::DIST_ROM[in_data.adc_sample[pot_pkg::ADC_BITS-1:0]];
        end
    end

    // period gate, state machine and obstacle tracking
    always_comb
    begin
        fsm_state_next     = fsm_state_reg;
        pending_state_next = pending_state_reg;
        last_update_next   = last_update_reg;
        last_change_next   = last_change_reg;
        last_dist_next     = last_dist_reg;
        tracked_dist_next  = tracked_dist_reg;
        tracked_valid_next = tracked_valid_reg;
        changed            = 1'b0;
        blocked            = 1'b0;

        since_update = s1_now_reg - last_update_reg;
        accept       = since_update >= {16'd0, update_period_reg};

        // running minimum for the current obstacle
        if (!tracked_valid_reg || (tracked_dist_reg > s1_dist_reg))
        begin
            obst_dist  = s1_dist_reg;
            obst_valid = 1'b1;
        end
        else
        begin
            obst_dist  = tracked_dist_reg;
            obst_valid = tracked_valid_reg;
        end
        near_limit = {1'b0, prox_limit_reg} + {1'b0, hyst_band_reg};

        if (accept)
        begin
            last_update_next = s1_now_reg;
            last_dist_next   = s1_dist_reg;
            changed          = fsm_state_reg != pending_state_reg;
            if (changed)
            begin
                last_change_next = s1_now_reg;
                fsm_state_next   = pending_state_reg;
            end
        end
        since_change = s1_now_reg - last_change_next;
        latched      = since_change >= {16'd0, latch_time_reg};
        // within the band of the closest reading and near enough
        blocked      = ((s1_dist_reg - obst_dist) < hyst_band_reg)
                       && ({1'b0, s1_dist_reg} <= near_limit);

        if (accept)
        begin
            unique case (fsm_state_next)
                pot_pkg::ST_STARTING:
                begin
                    pending_state_next = pot_pkg::ST_SCANNING;
                end
                pot_pkg::ST_SCANNING:
                begin
                    if (s1_dist_reg < prox_limit_reg)
                    begin
                        tracked_valid_next = 1'b0;
                        pending_state_next = pot_pkg::ST_FOUND;
                    end
                end
                pot_pkg::ST_FOUND:
                begin
                    tracked_dist_next  = obst_dist;
                    tracked_valid_next = obst_valid;
                    if (!blocked)
                    begin
                        pending_state_next = pot_pkg::ST_SCANNING;
                    end
                    else if (latched)
                    begin
                        pending_state_next = pot_pkg::ST_ALERT;
                    end
                end
                pot_pkg::ST_ALERT:
                begin
                    // stays in alert while blocked
                    tracked_dist_next  = obst_dist;
                    tracked_valid_next = obst_valid;
                    if (!blocked)
                    begin
                        pending_state_next = pot_pkg::ST_LOST;
                    end
                end
                pot_pkg::ST_LOST:
                begin
                    tracked_dist_next  = obst_dist;
                    tracked_valid_next = obst_valid;
                    if (blocked)
                    begin
                        pending_state_next = pot_pkg::ST_ALERT;
                    end
                    else if (latched)
                    begin
                        pending_state_next = pot_pkg::ST_SCANNING;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result assembly; an ignored sample reports the held values
    always_comb
    begin
        out_data_next.accepted          = accept;
        out_data_next.current_state     = fsm_state_next;
        out_data_next.state_changed     = changed;
        out_data_next.measured_distance = last_dist_next;
        out_data_next.obstacle_valid    = tracked_valid_next;
        out_data_next.obstacle_distance = tracked_valid_next ? tracked_dist_next : '0;
    end

    // tracker state commits only on a transfer out of the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_state_reg     <= pot_pkg::ST_STARTING;
            pending_state_reg <= pot_pkg::ST_SCANNING;
            last_update_reg   <= '0;
            last_change_reg   <= '0;
            last_dist_reg     <= '0;
            tracked_dist_reg  <= '0;
            tracked_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            fsm_state_reg     <= fsm_state_next;
            pending_state_reg <= pending_state_next;
            last_update_reg   <= last_update_next;
            last_change_reg   <= last_change_next;
            last_dist_reg     <= last_dist_next;
            tracked_dist_reg  <= tracked_dist_next;
            tracked_valid_reg <= tracked_valid_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
